FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the decimator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define SIDB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sidb assertion failed");

// Next-cycle implication, checked out of reset
`define SIDB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sidb assertion failed");

`endif

FILE: hw/rtl/sidb_pkg.sv
// Types, constants, coefficient ROM and microcode ROM of the decimator
package sidb_pkg;

	localparam int SECTIONS_DEF    = 6;
	localparam int DECIMATION_DEF  = 2;
	localparam int SAMPLE_BITS_DEF = 24;

	localparam int STATE_W    = 32;
	localparam int COEF_W     = 32;
	localparam int ACC_W      = 64;
	localparam int COEF_SHIFT = 28;
	localparam int RND_W      = ACC_W - COEF_SHIFT;
	localparam int ROM_ROWS   = 16;
	localparam int ROM_IDX_W  = 4;
	localparam int COEFS      = 5;

	localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(64'd1 << (COEF_SHIFT - 1));
	localparam logic signed [STATE_W-1:0] STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
	localparam logic signed [STATE_W-1:0] STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};

	typedef logic signed [STATE_W-1:0] state_t;
	typedef logic signed [COEF_W-1:0] coef_t;

	// One section's delay line, kept as one memory row
	typedef struct packed {
		state_t in1;
		state_t in2;
		state_t out1;
		state_t out2;
	} row_t;

	// Coefficient order within a ROM row: b0 b1 b2 a1 a2
	localparam coef_t ONE_Q28 = 32'sd268435456;
	localparam coef_t COEF_ROM [ROM_ROWS][COEFS] = '{
		'{32'sd282603, 32'sd525286, 32'sd282603, -32'sd279811988, 32'sd80196279},
		'{ONE_Q28, 32'sd294643141, ONE_Q28, -32'sd250777451, 32'sd114779952},
		'{ONE_Q28, 32'sd113955692, ONE_Q28, -32'sd211626754, 32'sd162324513},
		'{ONE_Q28, 32'sd9828037, ONE_Q28, -32'sd179151060, 32'sd204167253},
		'{ONE_Q28, -32'sd42538726, ONE_Q28, -32'sd159312577, 32'sd235064027},
		'{ONE_Q28, -32'sd64093089, ONE_Q28, -32'sd152292836, 32'sd258068806},
		'{ONE_Q28, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
		'{ONE_Q28, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
		'{ONE_Q28, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
		'{ONE_Q28, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
		'{ONE_Q28, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
		'{ONE_Q28, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
		'{ONE_Q28, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
		'{ONE_Q28, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
		'{ONE_Q28, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
		'{ONE_Q28, 32'sd0, 32'sd0, 32'sd0, 32'sd0}
	};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_MUL4,
		ST_ACC,
		ST_ROUND,
		ST_WRITE,
		ST_OUT
	} step_t;

	// Multiplier operand, doubles as coefficient column
	typedef enum logic [2:0] {
		OP_X0,
		OP_X1,
		OP_X2,
		OP_Y1,
		OP_Y2
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_WAIT_IN,
		JMP_LOOP,
		JMP_WAIT_OUT
	} jump_t;

	typedef struct packed {
		logic     rd_en;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     rnd_en;
		logic     wb_en;
		logic     out_en;
		jump_t    jump;
		step_t    target;
		step_t    alt;
	} ucode_t;

	// Sequencer to datapath control
	typedef struct packed {
		ucode_t word;
		logic   first_sec;
		logic   last_push;
		logic   capture_out;
		logic   load_in;
	} sidb_ctrl_t;

	localparam ucode_t UCODE_NOP = '{
		rd_en: 1'b0, mul_sel: OP_X0, acc_op: ACC_HOLD, rnd_en: 1'b0, wb_en: 1'b0,
		out_en: 1'b0, jump: JMP_NEXT, target: ST_IDLE, alt: ST_IDLE
	};

	// Microcode ROM: one control word per step
	function automatic ucode_t ucode_rom(step_t s);
		ucode_t w;
		w = UCODE_NOP;
		unique case (s)
			ST_IDLE: begin
				w.jump   = JMP_WAIT_IN;
				w.target = ST_READ;
			end
			ST_READ: begin
				w.rd_en  = 1'b1;
				w.target = ST_MUL0;
			end
			ST_MUL0: begin
				w.mul_sel = OP_X0;
				w.target  = ST_MUL1;
			end
			ST_MUL1: begin
				w.mul_sel = OP_X1;
				w.acc_op  = ACC_LOAD;
				w.target  = ST_MUL2;
			end
			ST_MUL2: begin
				w.mul_sel = OP_X2;
				w.acc_op  = ACC_ADD;
				w.target  = ST_MUL3;
			end
			ST_MUL3: begin
				w.mul_sel = OP_Y1;
				w.acc_op  = ACC_ADD;
				w.target  = ST_MUL4;
			end
			ST_MUL4: begin
				w.mul_sel = OP_Y2;
				w.acc_op  = ACC_SUB;
				w.target  = ST_ACC;
			end
			ST_ACC: begin
				w.acc_op = ACC_SUB;
				w.target = ST_ROUND;
			end
			ST_ROUND: begin
				w.rnd_en = 1'b1;
				w.target = ST_WRITE;
			end
			ST_WRITE: begin
				w.wb_en  = 1'b1;
				w.jump   = JMP_LOOP;
				w.target = ST_READ;
				w.alt    = ST_OUT;
			end
			ST_OUT: begin
				w.out_en = 1'b1;
				w.jump   = JMP_WAIT_OUT;
				w.target = ST_IDLE;
			end
			default: w = UCODE_NOP;
		endcase
		return w;
	endfunction

endpackage

FILE: hw/rtl/sidb_sequencer.sv
// Microcode sequencer: step counter, section and push counters, jumps
`include "assert_macros.svh"

module sidb_sequencer #(
	parameter int SECTIONS   = sidb_pkg::SECTIONS_DEF,
	parameter int DECIMATION = sidb_pkg::DECIMATION_DEF,
	parameter int SEC_W      = 3,
	parameter int PUSH_W     = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 out_free,
	output logic                 idle,
	output logic [SEC_W-1:0]     sec,
	output sidb_pkg::sidb_ctrl_t ctrl
);
	import sidb_pkg::*;

	localparam logic [SEC_W-1:0]  SEC_LAST  = SEC_W'(SECTIONS - 1);
	localparam logic [PUSH_W-1:0] PUSH_LAST = PUSH_W'(DECIMATION - 1);

	step_t             step_q, step_d;
	logic [SEC_W-1:0]  sec_q, sec_d;
	logic [PUSH_W-1:0] push_q, push_d;
	ucode_t            word;
	logic              accept;
	logic              last_push;
	logic              job_done;

	// Fetch the control word for the current step
	assign word      = ucode_rom(step_q);
	assign idle      = (step_q == ST_IDLE);
	assign accept    = idle && in_valid;
	assign last_push = (push_q == PUSH_LAST);
	assign job_done  = (sec_q == '0) && last_push;
	assign sec       = sec_q;

	assign ctrl.word        = word;
	assign ctrl.first_sec   = (sec_q == '0);
	assign ctrl.last_push   = last_push;
	assign ctrl.capture_out = word.wb_en && last_push && (sec_q == SEC_LAST);
	assign ctrl.load_in     = accept;

	// Advance step, section and push counters
	always_comb begin
		step_d = step_q;
		sec_d  = sec_q;
		push_d = push_q;
		unique case (word.jump)
			JMP_NEXT: step_d = word.target;
			JMP_WAIT_IN: begin
				if (accept) begin
					step_d = word.target;
					sec_d  = SEC_LAST;
					push_d = '0;
				end
			end
			JMP_LOOP: begin
				if (job_done) begin
					step_d = word.alt;
				end else if (sec_q != '0) begin
					step_d = word.target;
					sec_d  = sec_q - 1'b1;
				end else begin
					step_d = word.target;
					sec_d  = SEC_LAST;
					push_d = push_q + 1'b1;
				end
			end
			JMP_WAIT_OUT: begin
				if (out_free) begin
					step_d = word.target;
				end
			end
		endcase
	end

	// Hold sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
			sec_q  <= '0;
			push_q <= '0;
		end else begin
			step_q <= step_d;
			sec_q  <= sec_d;
			push_q <= push_d;
		end
	end

	`SIDB_ASSERT_NXT(a_accept_starts, clk, arst_n, accept,
		(step_q == ST_READ) && (sec_q == SEC_LAST) && (push_q == '0))
	`SIDB_ASSERT_NXT(a_done_to_out, clk, arst_n, (step_q == ST_WRITE) && job_done,
		step_q == ST_OUT)
	`SIDB_ASSERT_IMP(a_sec_range, clk, arst_n, 1'b1,
		(sec_q <= SEC_LAST) && (push_q <= PUSH_LAST))

endmodule

FILE: hw/rtl/sidb_datapath.sv
// Datapath: delay-line memory, shared MAC, rounding, saturation, output word
`include "assert_macros.svh"

module sidb_datapath #(
	parameter int SECTIONS    = sidb_pkg::SECTIONS_DEF,
	parameter int SAMPLE_BITS = sidb_pkg::SAMPLE_BITS_DEF,
	parameter int SEC_W       = 3
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sidb_pkg::sidb_ctrl_t        ctrl,
	input  logic [SEC_W-1:0]            sec,
	input  logic signed [SAMPLE_BITS-1:0] sample_first,
	input  logic signed [SAMPLE_BITS-1:0] sample_second,
	input  logic                        out_stall,
	output logic                        out_free,
	output logic                        out_valid,
	output logic signed [SAMPLE_BITS-1:0] filtered_sample
);
	import sidb_pkg::*;

	row_t                      mem [SECTIONS];
	logic [SECTIONS-1:0]       valid_q;
	row_t                      rd_a_q;
	logic                      rd_a_vld_q;
	state_t                    rd_b_q;
	logic                      rd_b_vld_q;
	logic [SEC_W-1:0]          addr_b;
	logic signed [SAMPLE_BITS-1:0] first_q, second_q;
	row_t                      row_a;
	state_t                    x0;
	state_t                    opnd;
	coef_t                     coef;
	logic signed [ACC_W-1:0]   prod_s1;
	logic signed [ACC_W-1:0]   acc_q;
	logic [ACC_W-1:0]          rnd_sum;
	logic signed [RND_W-1:0]   rnd_q;
	logic [RND_W-STATE_W:0]    rnd_top;
	state_t                    sat32;
	state_t                    y_q;
	logic [STATE_W-SAMPLE_BITS:0] y_top;
	logic signed [SAMPLE_BITS-1:0] y_sat;
	logic                      out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;
	row_t                      new_row;

	// Capture the input word while the sequencer is idle
	always_ff @(posedge clk) begin
		if (ctrl.load_in) begin
			first_q  <= sample_first;
			second_q <= sample_second;
		end
	end

	// Read the section row and the previous section's output
	assign addr_b = (sec == '0) ? '0 : sec - 1'b1;

	always_ff @(posedge clk) begin
		if (ctrl.word.rd_en) begin
			rd_a_q     <= mem[sec];
			rd_a_vld_q <= valid_q[sec];
			rd_b_q     <= mem[addr_b].out1;
			rd_b_vld_q <= valid_q[addr_b];
		end
	end

	// Rows never written read as zero
	assign row_a = rd_a_vld_q ? rd_a_q : '0;

	always_comb begin
		if (ctrl.first_sec) begin
			x0 = ctrl.last_push ? STATE_W'(second_q) : STATE_W'(first_q);
		end else begin
			x0 = rd_b_vld_q ? rd_b_q : '0;
		end
	end

	// Select multiplier operand and coefficient
	always_comb begin
		unique case (ctrl.word.mul_sel)
			OP_X0:   opnd = x0;
			OP_X1:   opnd = row_a.in1;
			OP_X2:   opnd = row_a.in2;
			OP_Y1:   opnd = row_a.out1;
			OP_Y2:   opnd = row_a.out2;
			default: opnd = '0;
		endcase
	end

	assign coef = COEF_ROM[ROM_IDX_W'(sec)][ctrl.word.mul_sel];

	// Multiply, then accumulate the registered product
	always_ff @(posedge clk) begin
		prod_s1 <= coef * opnd;
		unique case (ctrl.word.acc_op)
			ACC_HOLD: acc_q <= acc_q;
			ACC_LOAD: acc_q <= prod_s1;
			ACC_ADD:  acc_q <= acc_q + prod_s1;
			ACC_SUB:  acc_q <= acc_q - prod_s1;
		endcase
	end

	// Round to nearest, ties up, and drop the fraction bits
	assign rnd_sum = acc_q + RND_HALF;

	always_ff @(posedge clk) begin
		if (ctrl.word.rnd_en) begin
			rnd_q <= rnd_sum[ACC_W-1:COEF_SHIFT];
		end
	end

	// Saturate the section result to the state range
	assign rnd_top = rnd_q[RND_W-1:STATE_W-1];
	always_comb begin
		if ((&rnd_top) || !(|rnd_top)) begin
			sat32 = rnd_q[STATE_W-1:0];
		end else begin
			sat32 = rnd_q[RND_W-1] ? STATE_MIN : STATE_MAX;
		end
	end

	// Shift the section's delay line
	assign new_row.in1  = x0;
	assign new_row.in2  = row_a.in1;
	assign new_row.out1 = sat32;
	assign new_row.out2 = row_a.out1;

	always_ff @(posedge clk) begin
		if (ctrl.word.wb_en) begin
			mem[sec] <= new_row;
		end
		if (ctrl.capture_out) begin
			y_q <= sat32;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctrl.word.wb_en) begin
			valid_q[sec] <= 1'b1;
		end
	end

	// Saturate the last section's output to the sample width
	assign y_top = y_q[STATE_W-1:SAMPLE_BITS-1];
	always_comb begin
		if ((&y_top) || !(|y_top)) begin
			y_sat = y_q[SAMPLE_BITS-1:0];
		end else begin
			y_sat = y_q[STATE_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
			                       : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	end

	// Hold the output word until taken
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.word.out_en && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.word.out_en && out_free) begin
			out_data_q <= y_sat;
		end
	end

	assign out_valid       = out_valid_q;
	assign filtered_sample = out_data_q;

	`SIDB_ASSERT_NXT(a_round_before_write, clk, arst_n, ctrl.word.rnd_en, ctrl.word.wb_en)
	`SIDB_ASSERT_IMP(a_capture_on_write, clk, arst_n, ctrl.capture_out, ctrl.word.wb_en)
	`SIDB_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid_q && out_stall, out_valid_q && $stable(out_data_q))

endmodule

FILE: hw/rtl/sos_iir_decimator_by_two_unit.sv
// Top level of the cascaded biquad decimator
// A single shared multiply-accumulate unit steps through nine microcode steps per section per sample.
// A new input word is taken only between jobs; the next input word is taken while the previous
// output word waits. Reset clears all filter delay state and the output.
module sos_iir_decimator_by_two_unit #(
	parameter int SECTIONS    = sidb_pkg::SECTIONS_DEF,
	parameter int DECIMATION  = sidb_pkg::DECIMATION_DEF,
	parameter int SAMPLE_BITS = sidb_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_first,
	input  logic signed [SAMPLE_BITS-1:0] sample_second,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] filtered_sample
);
	import sidb_pkg::*;

	localparam int SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
	localparam int PUSH_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

	sidb_ctrl_t       ctrl;
	logic [SEC_W-1:0] sec;
	logic             idle;
	logic             out_free;

	// Take a new word only between jobs
	assign in_stall = !idle;

	sidb_sequencer #(
		.SECTIONS  (SECTIONS),
		.DECIMATION(DECIMATION),
		.SEC_W     (SEC_W),
		.PUSH_W    (PUSH_W)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.out_free(out_free),
		.idle    (idle),
		.sec     (sec),
		.ctrl    (ctrl)
	);

	sidb_datapath #(
		.SECTIONS   (SECTIONS),
		.SAMPLE_BITS(SAMPLE_BITS),
		.SEC_W      (SEC_W)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.sec            (sec),
		.sample_first   (sample_first),
		.sample_second  (sample_second),
		.out_stall      (out_stall),
		.out_free       (out_free),
		.out_valid      (out_valid),
		.filtered_sample(filtered_sample)
	);

endmodule
